### src/ssd_pkg.sv
// ssd_pkg: shared types, codes, segment constants and font for the display controller.
// No dependencies; imported by ssd_front, ssd_back and the top level.
`default_nettype none

package ssd_pkg;

    // Default configuration
    localparam int DIGIT_COUNT_DEF  = 6;
    localparam int BUFFER_DEPTH_DEF = 7;
    localparam int MAX_DIGIT_COUNT  = 8;

    // Active-low segment codes
    localparam logic [7:0] SEG_BLANK      = 8'hFF;
    localparam logic [7:0] SEG_DASH       = 8'hBF;
    localparam logic [7:0] SEG_POINT_MASK = 8'h7F;

    // floor(n / 10) == (n * DIV10_MAGIC) >> DIV10_SHIFT for every 32-bit n
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // Command codes
    typedef enum logic [1:0] {
        CMD_WRITE_NUMBER = 2'd0,
        CMD_WRITE_POS    = 2'd1,
        CMD_SCAN         = 2'd2
    } cmd_t;

    // Classified command, with its decimal digits once the front is done
    typedef struct packed {
        cmd_t                             cmd;
        logic [2:0]                       position;
        logic                             point_on;
        logic [3:0]                       low_digit;
        logic [MAX_DIGIT_COUNT-1:0][3:0]  digits;
    } ssd_item_t;

    // One result transaction
    typedef struct packed {
        logic [2:0] scan_position;
        logic [7:0] segments;
        logic [3:0] echo_digit;
    } ssd_result_t;

    // Hex font, active low
    function automatic logic [7:0] hex_font(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'h0:    code = 8'hC0;
            4'h1:    code = 8'hF9;
            4'h2:    code = 8'hA4;
            4'h3:    code = 8'hB0;
            4'h4:    code = 8'h99;
            4'h5:    code = 8'h92;
            4'h6:    code = 8'h82;
            4'h7:    code = 8'hF8;
            4'h8:    code = 8'h80;
            4'h9:    code = 8'h90;
            4'hA:    code = 8'h88;
            4'hB:    code = 8'h83;
            4'hC:    code = 8'hC6;
            4'hD:    code = 8'hA1;
            4'hE:    code = 8'h86;
            4'hF:    code = 8'h8E;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### src/ssd_fifo.sv
// ssd_fifo: small generic register-based queue used between the display controller parts.
// Depends on nothing; payload is a flat vector of WIDTH bits.
`default_nettype none

module ssd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### src/ssd_front.sv
// ssd_front: accepts and classifies commands, splits the number into decimal digits,
// one digit per pipeline stage. Depends on ssd_pkg.
`default_nettype none

module ssd_front
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] number,
    input  wire logic [2:0]  position,
    input  wire logic        point_on,
    output logic             full,
    output logic             out_valid,
    output ssd_item_t        out_item,
    input  wire logic        out_ready
);

    logic        valid_reg [DIGIT_COUNT];
    ssd_item_t   item_reg  [DIGIT_COUNT];
    logic [31:0] quot_reg  [DIGIT_COUNT];
    logic        stage_ready [DIGIT_COUNT+1];
    logic        cmd_ok;
    ssd_item_t   first_item;

    // Classification: the unused code is dropped here
    assign cmd_ok = (cmd == CMD_WRITE_NUMBER) || (cmd == CMD_WRITE_POS) || (cmd == CMD_SCAN);

    always_comb
    begin
        first_item           = '0;
        first_item.cmd       = cmd_t'(cmd);
        first_item.position  = position;
        first_item.point_on  = point_on;
        first_item.low_digit = number[3:0];
    end

    // A stage moves when it is empty or the one after it moves
    always_comb
    begin
        stage_ready[DIGIT_COUNT] = out_ready;
        for (int i = DIGIT_COUNT - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign full      = !stage_ready[0];
    assign out_valid = valid_reg[DIGIT_COUNT-1];
    assign out_item  = item_reg[DIGIT_COUNT-1];

    // Digit stages: divide by ten with a reciprocal multiply, keep the remainder
    for (genvar i = 0; i < DIGIT_COUNT; i++)
    begin : g_stage
        logic [31:0] n_in;
        ssd_item_t   item_in;
        logic        valid_in;
        logic [63:0] prod;
        logic [31:0] quot_next;
        logic [31:0] rem_full;
        ssd_item_t   item_next;

        if (i == 0)
        begin : g_first
            assign n_in     = number;
            assign item_in  = first_item;
            assign valid_in = push && cmd_ok;
        end
        else
        begin : g_rest
            assign n_in     = quot_reg[i-1];
            assign item_in  = item_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        always_comb
        begin
            prod      = {32'd0, n_in} * {32'd0, DIV10_MAGIC};
            quot_next = {3'd0, prod[63:DIV10_SHIFT]};
            rem_full  = n_in - ((quot_next << 3) + (quot_next << 1));
            item_next = item_in;
            item_next.digits[i] = rem_full[3:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (stage_ready[i])
            begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[i])
            begin
                item_reg[i] <= item_next;
                quot_reg[i] <= quot_next;
            end
        end
    end

endmodule

`default_nettype wire

### src/ssd_back.sv
// ssd_back: executes classified commands on the segment buffer and scan pointer,
// producing result transactions. Depends on ssd_pkg.
`default_nettype none

module ssd_back
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT  = DIGIT_COUNT_DEF,
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire ssd_item_t in_item,
    output logic           in_ready,
    input  wire logic      res_full,
    output logic           res_push,
    output ssd_result_t    res_data
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    logic [7:0]             seg_buf_reg  [BUFFER_DEPTH];
    logic [7:0]             seg_buf_next [BUFFER_DEPTH];
    logic [2:0]             scan_ptr_reg, scan_ptr_next;
    logic                   needs_result;
    logic                   take;
    logic [DIGIT_COUNT-1:0] hit;
    logic [DIGIT_COUNT-1:0] font_sel;
    logic                   pos_ok;
    logic [7:0]             pos_seg;

    assign needs_result = (in_item.cmd != CMD_WRITE_NUMBER);
    assign take         = in_valid && (!needs_result || !res_full);
    assign in_ready     = take;
    assign res_push     = take && needs_result;

    // Leading-zero walk: a position gets its font code when a nonzero digit
    // at or above it stops the walk (position 2 never stops it; position 0 always gets it)
    always_comb
    begin
        logic acc;
        acc = 1'b0;
        for (int k = DIGIT_COUNT - 1; k >= 0; k--)
        begin
            hit[k]      = (k >= 1) && (k != 2) && (in_item.digits[k] != 4'd0);
            acc         = acc || hit[k];
            font_sel[k] = acc || (k == 0);
        end
    end

    // Single-position write value
    assign pos_ok  = ({1'b0, in_item.position} < 4'(BUFFER_DEPTH));
    assign pos_seg = !pos_ok ? SEG_BLANK :
                     in_item.point_on ? (hex_font(in_item.low_digit) & SEG_POINT_MASK) :
                     hex_font(in_item.low_digit);

    // Command execution
    always_comb
    begin
        seg_buf_next  = seg_buf_reg;
        scan_ptr_next = scan_ptr_reg;
        res_data      = '0;
        case (in_item.cmd)
            CMD_WRITE_NUMBER:
            begin
                for (int p = 0; p < BUFFER_DEPTH; p++)
                begin
                    if (p < DIGIT_COUNT)
                    begin
                        if (font_sel[p])
                        begin
                            seg_buf_next[p] = hex_font(in_item.digits[p]);
                        end
                        else if (p == 2)
                        begin
                            seg_buf_next[p] = SEG_DASH;
                        end
                        else if (p == 1)
                        begin
                            // blanked position 1 shows '0'
                            seg_buf_next[p] = hex_font(4'd0);
                        end
                        else
                        begin
                            seg_buf_next[p] = SEG_BLANK;
                        end
                    end
                end
            end
            CMD_WRITE_POS:
            begin
                if (pos_ok)
                begin
                    seg_buf_next[in_item.position[IDX_W-1:0]] = pos_seg;
                end
                res_data.scan_position = in_item.position;
                res_data.segments      = pos_seg;
                res_data.echo_digit    = in_item.low_digit;
            end
            CMD_SCAN:
            begin
                res_data.scan_position = scan_ptr_reg;
                res_data.segments      = seg_buf_reg[scan_ptr_reg[IDX_W-1:0]];
                res_data.echo_digit    = 4'd0;
                scan_ptr_next = (scan_ptr_reg == 3'(BUFFER_DEPTH - 1)) ? 3'd0
                                                                       : scan_ptr_reg + 3'd1;
            end
            default:
            begin
                res_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < BUFFER_DEPTH; p++)
            begin
                seg_buf_reg[p] <= SEG_BLANK;
            end
            scan_ptr_reg <= 3'd0;
        end
        else if (take)
        begin
            seg_buf_reg  <= seg_buf_next;
            scan_ptr_reg <= scan_ptr_next;
        end
    end

endmodule

`default_nettype wire

### src/seven_segment_display_controller_top.sv
// Top level of the multiplexed seven-segment display controller.
// Depends on ssd_pkg, ssd_front, ssd_fifo and ssd_back.
`default_nettype none

// Command transactions enter through a push/full queue port and results leave
// through an empty/pop queue port. One transaction is taken per clock cycle
// while full is low; back-pressure from the queues can raise full. A
// transaction first passes DIGIT_COUNT front stages, each of which peels one
// decimal digit off the number with a 32x32 reciprocal multiply, then a
// two-entry command queue, then the back end that updates the segment buffer
// and scan pointer; results wait in a two-entry result queue. Commands execute
// strictly in order, so a scan tick always sees every earlier write. The
// unused command code is accepted and discarded. Segment bytes are active low;
// after reset all positions are blank and the scan pointer is at position 0.
module seven_segment_display_controller_top
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT  = DIGIT_COUNT_DEF,
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] number,
    input  wire logic [2:0]  position,
    input  wire logic        point_on,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       scan_position,
    output logic [7:0]       segments,
    output logic [3:0]       echo_digit
);

    localparam int QUEUE_DEPTH = 2;
    localparam int ITEM_W      = $bits(ssd_item_t);
    localparam int RESULT_W    = $bits(ssd_result_t);

    logic        front_valid;
    ssd_item_t   front_item;
    logic        cmdq_full;
    logic        cmdq_empty;
    ssd_item_t   cmdq_item;
    logic        back_ready;
    logic        res_push;
    logic        res_full;
    ssd_result_t res_in;
    ssd_result_t res_out;

    // Front: accept, classify, split digits
    ssd_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd       (cmd),
        .number    (number),
        .position  (position),
        .point_on  (point_on),
        .full      (full),
        .out_valid (front_valid),
        .out_item  (front_item),
        .out_ready (!cmdq_full)
    );

    // Command queue between front and back
    ssd_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_valid),
        .wr_data (front_item),
        .full    (cmdq_full),
        .pop     (back_ready),
        .rd_data (cmdq_item),
        .empty   (cmdq_empty)
    );

    // Back: buffer and scan pointer
    ssd_back #(
        .DIGIT_COUNT  (DIGIT_COUNT),
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!cmdq_empty),
        .in_item  (cmdq_item),
        .in_ready (back_ready),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (res_in)
    );

    // Result queue toward the consumer
    ssd_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign scan_position = res_out.scan_position;
    assign segments      = res_out.segments;
    assign echo_digit    = res_out.echo_digit;

endmodule

`default_nettype wire
